// ===== hdl/mqms_pkg.sv =====
// shared constants, codes, types and helpers for the multi-queue mailbox
// no dependencies
package mqms_pkg;

    // sizing
    localparam int NUM_QUEUES  = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int NUM_SETS    = 3;
    localparam int SET_DEPTH   = 16;

    // field widths fixed by the interface
    localparam int CMD_W   = 3;
    localparam int QIDX_W  = 3;
    localparam int SIDX_W  = 2;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 5;
    localparam int MEMB_W  = 16;

    // derived widths
    localparam int QA_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int SA_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int QP_W  = $clog2(QUEUE_DEPTH);
    localparam int QF_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SP_W  = $clog2(SET_DEPTH);
    localparam int SF_W  = $clog2(SET_DEPTH + 1);
    localparam int MSG_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int SET_MEM_DEPTH = NUM_SETS * SET_DEPTH;
    localparam int MA_W  = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
    localparam int SMA_W = (SET_MEM_DEPTH > 1) ? $clog2(SET_MEM_DEPTH) : 1;

    // commands
    localparam logic [CMD_W-1:0] CMD_SEND  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RECV  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RSTQ  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RSTS  = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STAT_W-1:0] ST_SETFULL = 3'd3;
    localparam logic [STAT_W-1:0] ST_REFUSED = 3'd4;

    // memory requests from the control unit
    typedef struct packed {
        logic                  msg_we;
        logic [MA_W-1:0]       msg_waddr;
        logic [DATA_WIDTH-1:0] msg_wdata;
        logic [MA_W-1:0]       msg_raddr;
        logic                  set_we;
        logic [SMA_W-1:0]      set_waddr;
        logic [QIDX_W-1:0]     set_wdata;
        logic [SMA_W-1:0]      set_raddr;
    } t_mem_req;

    // result of one command, minus the memory read data
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  filled;
        logic [CNT_W-1:0]  avail;
        logic              take_msg;
        logic              take_set;
    } t_cmd_res;

    // counts saturate at the top of the field
    function automatic logic [CNT_W-1:0] sat_cnt(input logic [15:0] v);
        logic [CNT_W-1:0] r;
        r = (v > 16'((1 << CNT_W) - 1)) ? {CNT_W{1'b1}} : v[CNT_W-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/mqms_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module mqms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mqms_ctrl.sv =====
// command decode, queue and set pointer file, memory request generation
// depends on mqms_pkg
module mqms_ctrl
    import mqms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [QIDX_W-1:0] i_queue_index,
    input  logic [SIDX_W-1:0] i_set_index,
    input  logic [WORD_W-1:0] i_message_data,
    input  logic [MEMB_W-1:0] i_membership,
    output t_mem_req          o_req,
    output t_cmd_res          o_res
);

    logic [QP_W-1:0] r_q_rp [NUM_QUEUES];
    logic [QP_W-1:0] r_q_wp [NUM_QUEUES];
    logic [QF_W-1:0] r_q_fill [NUM_QUEUES];
    logic [SP_W-1:0] r_s_rp [NUM_SETS];
    logic [SP_W-1:0] r_s_wp [NUM_SETS];
    logic [SF_W-1:0] r_s_fill [NUM_SETS];

    logic [QP_W-1:0] n_q_rp;
    logic [QP_W-1:0] n_q_wp;
    logic [QF_W-1:0] n_q_fill;
    logic            n_q_upd;
    logic [SP_W-1:0] n_s_rp;
    logic [SP_W-1:0] n_s_wp;
    logic [SF_W-1:0] n_s_fill;
    logic            n_s_upd;

    logic            q_ok;
    logic [QA_W-1:0] q_idx;
    logic [1:0]      memb;
    logic            has_parent;
    logic [1:0]      parent;
    logic            s_ok;
    logic [SA_W-1:0] s_idx;
    logic [QP_W-1:0] q_rp;
    logic [QP_W-1:0] q_wp;
    logic [QF_W-1:0] q_fill;
    logic [SP_W-1:0] s_rp;
    logic [SP_W-1:0] s_wp;
    logic [SF_W-1:0] s_fill;

    // parent of the target queue: zero or a set that does not exist means none
    assign memb       = i_membership[{i_queue_index, 1'b0} +: 2];
    assign has_parent = (memb != 2'd0) && (memb <= 2'(NUM_SETS));
    assign parent     = memb - 2'd1;

    assign q_ok  = 32'(i_queue_index) < 32'(NUM_QUEUES);
    assign q_idx = q_ok ? QA_W'(i_queue_index) : '0;

    // send works on the parent set, select and set reset on the named set
    always_comb begin
        if (i_command == CMD_SEND) begin
            s_ok  = has_parent;
            s_idx = has_parent ? SA_W'(parent) : '0;
        end else begin
            s_ok  = 32'(i_set_index) < 32'(NUM_SETS);
            s_idx = (32'(i_set_index) < 32'(NUM_SETS)) ? SA_W'(i_set_index) : '0;
        end
    end

    assign q_rp   = r_q_rp[q_idx];
    assign q_wp   = r_q_wp[q_idx];
    assign q_fill = r_q_fill[q_idx];
    assign s_rp   = r_s_rp[s_idx];
    assign s_wp   = r_s_wp[s_idx];
    assign s_fill = r_s_fill[s_idx];

    always_comb begin
        n_q_rp   = q_rp;
        n_q_wp   = q_wp;
        n_q_fill = q_fill;
        n_q_upd  = 1'b0;
        n_s_rp   = s_rp;
        n_s_wp   = s_wp;
        n_s_fill = s_fill;
        n_s_upd  = 1'b0;

        o_req.msg_we    = 1'b0;
        o_req.msg_waddr = MA_W'(q_idx) * MA_W'(QUEUE_DEPTH) + MA_W'(q_wp);
        o_req.msg_wdata = DATA_WIDTH'(i_message_data);
        o_req.msg_raddr = MA_W'(q_idx) * MA_W'(QUEUE_DEPTH) + MA_W'(q_rp);
        o_req.set_we    = 1'b0;
        o_req.set_waddr = SMA_W'(s_idx) * SMA_W'(SET_DEPTH) + SMA_W'(s_wp);
        o_req.set_wdata = i_queue_index;
        o_req.set_raddr = SMA_W'(s_idx) * SMA_W'(SET_DEPTH) + SMA_W'(s_rp);

        o_res.status   = ST_OK;
        o_res.filled   = '0;
        o_res.avail    = '0;
        o_res.take_msg = 1'b0;
        o_res.take_set = 1'b0;

        case (i_command)
            CMD_SEND: begin
                if (!q_ok || q_fill >= QF_W'(QUEUE_DEPTH)) begin
                    o_res.status = ST_FULL;
                end else if (has_parent && s_fill >= SF_W'(SET_DEPTH)) begin
                    o_res.status = ST_SETFULL;
                end else begin
                    o_req.msg_we = 1'b1;
                    n_q_wp   = (q_wp == QP_W'(QUEUE_DEPTH - 1)) ? '0 : q_wp + 1'b1;
                    n_q_fill = q_fill + 1'b1;
                    n_q_upd  = 1'b1;
                    if (has_parent) begin
                        o_req.set_we = 1'b1;
                        n_s_wp   = (s_wp == SP_W'(SET_DEPTH - 1)) ? '0 : s_wp + 1'b1;
                        n_s_fill = s_fill + 1'b1;
                        n_s_upd  = 1'b1;
                    end
                end
            end
            CMD_RECV: begin
                if (!q_ok || q_fill == '0) begin
                    o_res.status = ST_EMPTY;
                end else begin
                    o_res.take_msg = 1'b1;
                    n_q_rp   = (q_rp == QP_W'(QUEUE_DEPTH - 1)) ? '0 : q_rp + 1'b1;
                    n_q_fill = q_fill - 1'b1;
                    n_q_upd  = 1'b1;
                end
            end
            CMD_RSTQ: begin
                // a member queue that still holds words keeps them
                if (!q_ok || (has_parent && q_fill != '0)) begin
                    o_res.status = ST_REFUSED;
                end else begin
                    n_q_rp   = '0;
                    n_q_wp   = '0;
                    n_q_fill = '0;
                    n_q_upd  = 1'b1;
                end
            end
            CMD_SEL: begin
                if (!s_ok || s_fill == '0) begin
                    o_res.status = ST_EMPTY;
                end else begin
                    o_res.take_set = 1'b1;
                    n_s_rp   = (s_rp == SP_W'(SET_DEPTH - 1)) ? '0 : s_rp + 1'b1;
                    n_s_fill = s_fill - 1'b1;
                    n_s_upd  = 1'b1;
                end
            end
            CMD_RSTS: begin
                if (!s_ok) begin
                    o_res.status = ST_REFUSED;
                end else begin
                    n_s_rp   = '0;
                    n_s_wp   = '0;
                    n_s_fill = '0;
                    n_s_upd  = 1'b1;
                end
            end
            default: begin
                o_res.status = ST_OK;
            end
        endcase

        // counts of the target after the step
        if ((i_command == CMD_SEND || i_command == CMD_RECV || i_command == CMD_RSTQ)
                && q_ok) begin
            o_res.filled = sat_cnt(16'(n_q_fill));
            o_res.avail  = sat_cnt(16'(QUEUE_DEPTH) - 16'(n_q_fill));
        end else if ((i_command == CMD_SEL || i_command == CMD_RSTS) && s_ok) begin
            o_res.filled = sat_cnt(16'(n_s_fill));
            o_res.avail  = sat_cnt(16'(SET_DEPTH) - 16'(n_s_fill));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_q_rp[i]   <= '0;
                r_q_wp[i]   <= '0;
                r_q_fill[i] <= '0;
            end
            for (int i = 0; i < NUM_SETS; i++) begin
                r_s_rp[i]   <= '0;
                r_s_wp[i]   <= '0;
                r_s_fill[i] <= '0;
            end
        end else if (i_accept) begin
            if (n_q_upd) begin
                r_q_rp[q_idx]   <= n_q_rp;
                r_q_wp[q_idx]   <= n_q_wp;
                r_q_fill[q_idx] <= n_q_fill;
            end
            if (n_s_upd) begin
                r_s_rp[s_idx]   <= n_s_rp;
                r_s_wp[s_idx]   <= n_s_wp;
                r_s_fill[s_idx] <= n_s_fill;
            end
        end
    end

endmodule

// ===== hdl/multi_queue_mailbox_with_sets_core.sv =====
// top level of the multi-queue mailbox with queue sets
// depends on mqms_pkg, mqms_ctrl and mqms_ram
//
// usage
//   command channel: i_in_valid / o_in_stall carry one command word
//   (command, queue index, set index, message data); it is taken at an
//   edge where valid is high and stall is low
//   result channel: o_out_valid / i_out_stall carry one result word per
//   command (status, read data, ready queue, held and free counts)
//   configuration: i_cfg_valid / o_cfg_ready write the set membership
//   register; ready is always high, write only while the block is idle
// timing
//   one command at a time: the accept edge updates the pointer file
//   and starts the message or set memory access, the next edge loads the
//   result register from the registered memory read data
//   o_out_valid rises at that load edge, so the result word can be taken
//   at the edge after it at the earliest
// reset
//   all queues and sets empty, membership zero, no result pending; the
//   message and set memories are not cleared, only written slots are read
// back-pressure
//   while the result is stalled the block takes no new command; the result
//   register holds its word until it is taken
module multi_queue_mailbox_with_sets_core
    import mqms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [QIDX_W-1:0] i_queue_index,
    input  logic [SIDX_W-1:0] i_set_index,
    input  logic [WORD_W-1:0] i_message_data,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [WORD_W-1:0] o_read_data,
    output logic [QIDX_W-1:0] o_ready_queue,
    output logic [CNT_W-1:0]  o_held_count,
    output logic [CNT_W-1:0]  o_available_count,
    // configuration channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MEMB_W-1:0] i_cfg_data
);

    logic [MEMB_W-1:0]     r_membership;
    logic                  r_busy;      // command in flight, result loads next edge
    logic                  r_out_valid;
    t_cmd_res              r_pend;      // decoded result awaiting memory data
    logic [STAT_W-1:0]     r_status;
    logic [WORD_W-1:0]     r_read_data;
    logic [QIDX_W-1:0]     r_ready_queue;
    logic [CNT_W-1:0]      r_filled;
    logic [CNT_W-1:0]      r_avail;

    logic                  in_acc;
    t_mem_req              mem_req;
    t_cmd_res              cmd_res;
    logic [DATA_WIDTH-1:0] msg_rdata;
    logic [QIDX_W-1:0]     set_rdata;

    // one command at a time; the result slot must be free by the load edge
    assign o_in_stall  = r_busy | (r_out_valid & i_out_stall);
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_membership <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_membership <= i_cfg_data;
        end
    end

    mqms_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_acc),
        .i_command      (i_command),
        .i_queue_index  (i_queue_index),
        .i_set_index    (i_set_index),
        .i_message_data (i_message_data),
        .i_membership   (r_membership),
        .o_req          (mem_req),
        .o_res          (cmd_res)
    );

    // message words, one ring of QUEUE_DEPTH slots per queue
    mqms_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MSG_DEPTH)
    ) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.msg_we & in_acc),
        .i_waddr (mem_req.msg_waddr),
        .i_wdata (mem_req.msg_wdata),
        .i_raddr (mem_req.msg_raddr),
        .o_rdata (msg_rdata)
    );

    // queue indices, one ring of SET_DEPTH slots per set
    mqms_ram #(
        .WIDTH (QIDX_W),
        .DEPTH (SET_MEM_DEPTH)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.set_we & in_acc),
        .i_waddr (mem_req.set_waddr),
        .i_wdata (mem_req.set_wdata),
        .i_raddr (mem_req.set_raddr),
        .o_rdata (set_rdata)
    );

    // control: busy flag and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= in_acc;
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: decoded result at accept, memory data merged at the next edge
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pend <= cmd_res;
        end
        if (r_busy) begin
            r_status      <= r_pend.status;
            r_filled      <= r_pend.filled;
            r_avail       <= r_pend.avail;
            r_read_data   <= r_pend.take_msg ? WORD_W'(msg_rdata) : '0;
            r_ready_queue <= r_pend.take_set ? set_rdata : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_read_data       = r_read_data;
    assign o_ready_queue     = r_ready_queue;
    assign o_held_count      = r_filled;
    assign o_available_count = r_avail;

`ifndef SYNTHESIS
    // every accepted command is followed by its memory stage
    a_acc_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_busy)
        else $error("accepted command did not enter the memory stage");

    // the memory stage always produces a result word
    a_busy_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> o_out_valid)
        else $error("result register not loaded after the memory stage");

    // a failed command returns no message or queue index
    a_fail_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_read_data == '0 && o_ready_queue == '0))
        else $error("failed command returned payload data");
`endif

endmodule
